// File: src/mhl_pkg.sv
// ----------------------------------------------------------------------------
// mhl_pkg
// Shared types and constants of the median hysteresis level block.
// ----------------------------------------------------------------------------
package mhl_pkg;

  localparam int VAL_W   = 16;
  localparam int AGE_W   = 7;
  localparam int CNT_W   = 3;
  localparam int LVL_W   = 2;
  localparam int SLOTS   = 4;
  localparam int IDX_W   = 2;
  localparam int SCALE_W = VAL_W + 4;

  localparam logic [AGE_W-1:0] AGE_MAX = 7'd127;

  typedef logic [LVL_W-1:0] level_t;

  localparam level_t LVL_WAIT = 2'd0;
  localparam level_t LVL_OK   = 2'd1;
  localparam level_t LVL_FAIR = 2'd2;
  localparam level_t LVL_POOR = 2'd3;

  localparam logic [IDX_W-1:0] CFG_FAIR_EDGE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_POOR_EDGE  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HAS_LIMITS = 2'd2;

  localparam logic [VAL_W-1:0] FAIR_EDGE_RESET = 16'd220;
  localparam logic [VAL_W-1:0] POOR_EDGE_RESET = 16'd650;

  typedef struct packed {
    logic [VAL_W-1:0] fair_edge;
    logic [VAL_W-1:0] poor_edge;
    logic             has_limits;
  } cfg_t;

endpackage

// File: src/mhl_median.sv
// ----------------------------------------------------------------------------
// mhl_median
// Median of the first one to four held values, newest first.
// ----------------------------------------------------------------------------
module mhl_median (
  input  logic [mhl_pkg::VAL_W-1:0] values [mhl_pkg::SLOTS],
  input  logic [mhl_pkg::CNT_W-1:0] count,
  output logic [mhl_pkg::VAL_W-1:0] median
);

  logic [mhl_pkg::VAL_W-1:0] lo_a;
  logic [mhl_pkg::VAL_W-1:0] hi_a;
  logic [mhl_pkg::VAL_W-1:0] lo_b;
  logic [mhl_pkg::VAL_W-1:0] hi_b;
  logic [mhl_pkg::VAL_W-1:0] mid_lo;
  logic [mhl_pkg::VAL_W-1:0] mid_hi;
  logic [mhl_pkg::VAL_W-1:0] med3;
  logic [mhl_pkg::VAL_W:0]   sum2;
  logic [mhl_pkg::VAL_W:0]   sum4;

  always_comb begin
    lo_a   = (values[0] < values[1]) ? values[0] : values[1];
    hi_a   = (values[0] < values[1]) ? values[1] : values[0];
    lo_b   = (values[2] < values[3]) ? values[2] : values[3];
    hi_b   = (values[2] < values[3]) ? values[3] : values[2];
    mid_lo = (lo_a > lo_b) ? lo_a : lo_b;
    mid_hi = (hi_a < hi_b) ? hi_a : hi_b;
    med3   = (hi_a < values[2]) ? hi_a : values[2];
    med3   = (lo_a > med3) ? lo_a : med3;
    sum2   = {1'b0, values[0]} + {1'b0, values[1]};
    sum4   = {1'b0, mid_lo} + {1'b0, mid_hi};
    case (count)
      3'd1:    median = values[0];
      3'd2:    median = sum2[mhl_pkg::VAL_W:1];
      3'd3:    median = med3;
      3'd4:    median = sum4[mhl_pkg::VAL_W:1];
      default: median = '0;
    endcase
  end

endmodule

// File: src/mhl_judge.sv
// ----------------------------------------------------------------------------
// mhl_judge
// Level classification of the median with hysteresis on the way down.
// ----------------------------------------------------------------------------
module mhl_judge (
  input  logic [mhl_pkg::VAL_W-1:0] median,
  input  logic                      present,
  input  mhl_pkg::level_t           prev_level,
  input  mhl_pkg::cfg_t             cfg,
  output mhl_pkg::level_t           level
);

  logic [mhl_pkg::SCALE_W-1:0] scaled_val;
  logic [mhl_pkg::SCALE_W-1:0] scaled_fair;
  logic [mhl_pkg::SCALE_W-1:0] scaled_poor;
  logic                        below_fair;
  logic                        below_poor;
  mhl_pkg::level_t             raw;
  mhl_pkg::level_t             held;
  mhl_pkg::level_t             judged;

  always_comb begin
    scaled_val  = {1'b0, median, 3'b000} + {3'b000, median, 1'b0};
    scaled_fair = {1'b0, cfg.fair_edge, 3'b000} + {4'b0000, cfg.fair_edge};
    scaled_poor = {1'b0, cfg.poor_edge, 3'b000} + {4'b0000, cfg.poor_edge};
    below_fair  = scaled_val < scaled_fair;
    below_poor  = scaled_val < scaled_poor;

    if (median >= cfg.poor_edge) begin
      raw = mhl_pkg::LVL_POOR;
    end else if (median >= cfg.fair_edge) begin
      raw = mhl_pkg::LVL_FAIR;
    end else begin
      raw = mhl_pkg::LVL_OK;
    end

    case (prev_level)
      mhl_pkg::LVL_POOR: begin
        if (raw != mhl_pkg::LVL_POOR && below_poor) begin
          held = (raw == mhl_pkg::LVL_OK && below_fair) ? mhl_pkg::LVL_OK
                                                         : mhl_pkg::LVL_FAIR;
        end else begin
          held = mhl_pkg::LVL_POOR;
        end
      end
      mhl_pkg::LVL_FAIR: begin
        held = (raw == mhl_pkg::LVL_OK && below_fair) ? mhl_pkg::LVL_OK
                                                       : mhl_pkg::LVL_FAIR;
      end
      default: held = raw;
    endcase

    judged = (held > raw) ? held : raw;

    if (!cfg.has_limits) begin
      level = mhl_pkg::LVL_OK;
    end else if (!present) begin
      level = mhl_pkg::LVL_WAIT;
    end else begin
      level = judged;
    end
  end

endmodule

// File: src/median_hysteresis_level.sv
// ----------------------------------------------------------------------------
// median_hysteresis_level
// Median of the newest valid sensor samples with a three-level rating.
// ----------------------------------------------------------------------------
// Each input request carries one sample on s_tdata and its valid flag on
// s_tuser; a request with the flag low is a gap that only ages the held values.
// Every input request produces exactly one output request with the median of
// the held values, a present flag and the level (wait, ok, fair, poor).
// The edges and the limits switch are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while no request is in flight, as the
// block does not enforce it. An unknown index is ignored. An accepted request
// is held in the input register, then the median, aging and rating logic writes
// the state and the output register. One request per cycle is sustained while
// m_tready is high; the rate is set by the single pass through the held-value
// update. When m_tready is low the result holds in the output register and
// one more request is still taken into an empty input register; after that
// s_tready drops. Reset empties both registers, forgets the held values, returns
// the level to wait and restores the edges to 220 and 650 with limits on.
// ----------------------------------------------------------------------------
module median_hysteresis_level #(
  parameter int RING_DEPTH   = 96,
  parameter int MEDIAN_COUNT = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,   // [15:0] sample_value
  input  logic                      s_tuser,   // [0] sample_valid
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,   // [15:0] display_value
  output logic [2:0]                m_tuser,   // [0] value_present, [2:1] level
  input  logic                      cfg_we,
  input  logic [mhl_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam logic [mhl_pkg::AGE_W-1:0] DEPTH_AGE = mhl_pkg::AGE_W'(RING_DEPTH);
  localparam logic [mhl_pkg::CNT_W-1:0] CAP       = mhl_pkg::CNT_W'(MEDIAN_COUNT);

  logic                        in_valid;
  logic [mhl_pkg::VAL_W-1:0]   in_value;
  logic                        in_flag;

  logic [mhl_pkg::VAL_W-1:0]   held_value [mhl_pkg::SLOTS];
  logic [mhl_pkg::AGE_W-1:0]   held_age [mhl_pkg::SLOTS];
  logic [mhl_pkg::CNT_W-1:0]   held_count;
  mhl_pkg::level_t             current_level;
  mhl_pkg::cfg_t               cfg;

  logic                        out_valid;
  logic [mhl_pkg::VAL_W-1:0]   out_value;
  logic                        out_present;
  mhl_pkg::level_t             out_level;

  logic [mhl_pkg::VAL_W-1:0]   held_value_next [mhl_pkg::SLOTS];
  logic [mhl_pkg::AGE_W-1:0]   held_age_next [mhl_pkg::SLOTS];
  logic [mhl_pkg::AGE_W-1:0]   aged [mhl_pkg::SLOTS];
  logic [mhl_pkg::CNT_W-1:0]   kept;
  logic                        keep_run;
  logic [mhl_pkg::CNT_W-1:0]   held_count_next;
  logic [mhl_pkg::VAL_W-1:0]   median;
  mhl_pkg::level_t             level;
  logic                        advance;
  logic                        step;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_comb begin
    keep_run = 1'b1;
    kept     = '0;
    for (int i = 0; i < mhl_pkg::SLOTS; i++) begin
      aged[i] = (held_age[i] == mhl_pkg::AGE_MAX) ? held_age[i]
                                                  : held_age[i] + 1'b1;
      if (keep_run && mhl_pkg::CNT_W'(i) < held_count && aged[i] < DEPTH_AGE) begin
        kept = mhl_pkg::CNT_W'(i + 1);
      end else begin
        keep_run = 1'b0;
      end
    end

    if (in_flag) begin
      held_value_next[0] = in_value;
      held_age_next[0]   = '0;
      for (int i = 1; i < mhl_pkg::SLOTS; i++) begin
        held_value_next[i] = held_value[i-1];
        held_age_next[i]   = aged[i-1];
      end
      held_count_next = (kept < CAP) ? kept + 1'b1 : kept;
    end else begin
      for (int i = 0; i < mhl_pkg::SLOTS; i++) begin
        held_value_next[i] = held_value[i];
        held_age_next[i]   = aged[i];
      end
      held_count_next = kept;
    end
  end

  mhl_median u_median (
    .values (held_value_next),
    .count  (held_count_next),
    .median (median)
  );

  mhl_judge u_judge (
    .median     (median),
    .present    (held_count_next != '0),
    .prev_level (current_level),
    .cfg        (cfg),
    .level      (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fair_edge  <= mhl_pkg::FAIR_EDGE_RESET;
      cfg.poor_edge  <= mhl_pkg::POOR_EDGE_RESET;
      cfg.has_limits <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        mhl_pkg::CFG_FAIR_EDGE:  cfg.fair_edge  <= cfg_data;
        mhl_pkg::CFG_POOR_EDGE:  cfg.poor_edge  <= cfg_data;
        mhl_pkg::CFG_HAS_LIMITS: cfg.has_limits <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_value <= s_tdata;
      in_flag  <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      current_level <= mhl_pkg::LVL_WAIT;
      for (int i = 0; i < mhl_pkg::SLOTS; i++) begin
        held_age[i] <= '0;
      end
    end else if (step) begin
      held_count    <= held_count_next;
      current_level <= level;
      for (int i = 0; i < mhl_pkg::SLOTS; i++) begin
        held_age[i] <= held_age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < mhl_pkg::SLOTS; i++) begin
        held_value[i] <= held_value_next[i];
      end
      out_value   <= median;
      out_present <= held_count_next != '0;
      out_level   <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = {out_level, out_present};

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    held_count <= CAP)
    else $error("held count exceeds the median window");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_present |-> out_value == '0)
    else $error("empty result carries a nonzero value");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_present |->
      (out_level == mhl_pkg::LVL_WAIT || out_level == mhl_pkg::LVL_OK))
    else $error("empty result carries a fair or poor level");

  a_no_limits: assert property (@(posedge clk) disable iff (rst)
    step && !cfg.has_limits |=> current_level == mhl_pkg::LVL_OK)
    else $error("level is not ok with limits off");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    step |=> current_level == out_level)
    else $error("stored level differs from the reported level");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the median hysteresis level block.
// ----------------------------------------------------------------------------
// Samples and gaps are streamed in while the result side applies random
// backpressure. A scoreboard class mirrors the held values, their ages, the
// current level and the registers, predicts one result per accepted request
// and compares each output request field by field against the oldest
// prediction. The edges and the limits switch are rewritten between phases
// while the block is idle, including equal, extreme and out-of-order edges.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RING_DEPTH = 96;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 140;

  typedef struct packed {
    logic [mhl_pkg::VAL_W-1:0] display_value;
    logic                      value_present;
    mhl_pkg::level_t           level;
  } rating_t;

  class level_scoreboard;
    logic [mhl_pkg::VAL_W-1:0] fair_edge;
    logic [mhl_pkg::VAL_W-1:0] poor_edge;
    logic                      has_limits;
    logic [mhl_pkg::VAL_W-1:0] held_val[mhl_pkg::SLOTS];
    int unsigned               held_age[mhl_pkg::SLOTS];
    int unsigned               held_cnt;
    mhl_pkg::level_t           cur_level;
    rating_t                   rating_q[$];
    int                        errors;

    function new();
      fair_edge = mhl_pkg::FAIR_EDGE_RESET;
      poor_edge = mhl_pkg::POOR_EDGE_RESET;
      has_limits = 1'b1;
      for (int i = 0; i < mhl_pkg::SLOTS; i++) begin
        held_val[i] = '0;
        held_age[i] = 0;
      end
      held_cnt = 0;
      cur_level = mhl_pkg::LVL_WAIT;
      errors = 0;
    endfunction

    function void write_reg(logic [mhl_pkg::IDX_W-1:0] idx,
                            logic [mhl_pkg::VAL_W-1:0] data);
      case (idx)
        mhl_pkg::CFG_FAIR_EDGE: fair_edge = data;
        mhl_pkg::CFG_POOR_EDGE: poor_edge = data;
        mhl_pkg::CFG_HAS_LIMITS: has_limits = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return rating_q.size();
    endfunction

    function logic [mhl_pkg::VAL_W-1:0] middle_of(int unsigned k);
      logic [mhl_pkg::VAL_W-1:0] v[mhl_pkg::SLOTS];
      logic [mhl_pkg::VAL_W-1:0] t;
      logic [mhl_pkg::VAL_W:0] sum;
      for (int i = 0; i < mhl_pkg::SLOTS; i++) v[i] = held_val[i];
      for (int i = 1; i < k; i++) begin
        for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
          t = v[j];
          v[j] = v[j-1];
          v[j-1] = t;
        end
      end
      if (k % 2 == 1) return v[k/2];
      sum = {1'b0, v[k/2-1]} + {1'b0, v[k/2]};
      return sum[mhl_pkg::VAL_W:1];
    endfunction

    function mhl_pkg::level_t rate(logic [mhl_pkg::VAL_W-1:0] med,
                                   mhl_pkg::level_t prev);
      mhl_pkg::level_t raw;
      mhl_pkg::level_t st;
      int unsigned edge_v;
      if (med >= poor_edge) raw = mhl_pkg::LVL_POOR;
      else if (med >= fair_edge) raw = mhl_pkg::LVL_FAIR;
      else raw = mhl_pkg::LVL_OK;
      if (prev != mhl_pkg::LVL_FAIR && prev != mhl_pkg::LVL_POOR) return raw;
      st = prev;
      while (st > raw) begin
        edge_v = (st == mhl_pkg::LVL_POOR) ? poor_edge : fair_edge;
        if (!(10 * int'(med) < 9 * edge_v)) break;
        st = (st == mhl_pkg::LVL_POOR) ? mhl_pkg::LVL_FAIR : mhl_pkg::LVL_OK;
      end
      return (st > raw) ? st : raw;
    endfunction

    function void note_input(logic [mhl_pkg::VAL_W-1:0] value, logic valid);
      int unsigned k;
      rating_t r;
      for (int i = 0; i < held_cnt; i++)
        if (held_age[i] < mhl_pkg::AGE_MAX) held_age[i]++;
      k = 0;
      while (k < held_cnt && held_age[k] < RING_DEPTH) k++;
      held_cnt = k;
      if (valid) begin
        for (int i = mhl_pkg::SLOTS - 1; i > 0; i--) begin
          held_val[i] = held_val[i-1];
          held_age[i] = held_age[i-1];
        end
        held_val[0] = value;
        held_age[0] = 0;
        if (held_cnt < mhl_pkg::SLOTS) held_cnt++;
      end
      r.display_value = (held_cnt > 0) ? middle_of(held_cnt) : '0;
      r.value_present = (held_cnt > 0);
      if (!has_limits) r.level = mhl_pkg::LVL_OK;
      else if (held_cnt == 0) r.level = mhl_pkg::LVL_WAIT;
      else r.level = rate(r.display_value, cur_level);
      cur_level = r.level;
      rating_q.push_back(r);
    endfunction

    function void check_result(logic [mhl_pkg::VAL_W-1:0] data, logic [2:0] user);
      rating_t exp_r;
      rating_t got;
      got.display_value = data;
      got.value_present = user[0];
      got.level = user[2:1];
      if (rating_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d present %0b level %0d",
                   got.display_value, got.value_present, got.level);
        return;
      end
      exp_r = rating_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                   exp_r.display_value, exp_r.value_present, exp_r.level,
                   got.display_value, got.value_present, got.level);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [15:0]               s_tdata = '0;     // [15:0] sample_value
  logic                      s_tuser = 1'b0;   // [0] sample_valid
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [15:0]               m_tdata;          // [15:0] display_value
  logic [2:0]                m_tuser;          // [0] value_present, [2:1] level
  logic                      cfg_we = 1'b0;
  logic [mhl_pkg::IDX_W-1:0] cfg_index = '0;
  logic [15:0]               cfg_data = '0;

  level_scoreboard sb = new();
  logic            calm = 1'b0;
  int unsigned     quiet_cycles = 0;

  median_hysteresis_level #(
    .RING_DEPTH(RING_DEPTH),
    .MEDIAN_COUNT(4)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] value, input logic valid);
    s_tdata <= value;
    s_tuser <= valid;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    while (!calm && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] fair, input logic [15:0] poor,
                            input logic limits, input logic bad_index);
    cfg_we <= 1'b1;
    cfg_index <= mhl_pkg::CFG_FAIR_EDGE;
    cfg_data <= fair;
    @(posedge clk);
    sb.write_reg(mhl_pkg::CFG_FAIR_EDGE, fair);
    cfg_index <= mhl_pkg::CFG_POOR_EDGE;
    cfg_data <= poor;
    @(posedge clk);
    sb.write_reg(mhl_pkg::CFG_POOR_EDGE, poor);
    cfg_index <= mhl_pkg::CFG_HAS_LIMITS;
    cfg_data <= {15'h7ffe, limits};
    @(posedge clk);
    sb.write_reg(mhl_pkg::CFG_HAS_LIMITS, {15'h7ffe, limits});
    if (bad_index) begin
      cfg_index <= 2'd3;
      cfg_data <= 16'hffff;
      @(posedge clk);
      sb.write_reg(2'd3, 16'hffff);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int unsigned e;
    int t;
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: begin
        e = $urandom_range(1) ? sb.poor_edge : sb.fair_edge;
        if ($urandom_range(1)) e = (e * 9) / 10;
        t = int'(e) + int'($urandom_range(8)) - 4;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return t[15:0];
      end
    endcase
  endfunction

  task automatic random_items(input int n);
    int count;
    int kind;
    int len;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(12, 1);
        repeat (len) send_sample(pick_value(), 1'b1);
      end else if (kind < 78) begin
        len = $urandom_range(8, 1);
        repeat (len) send_sample(pick_value(), 1'($urandom_range(1)));
      end else if (kind < 96) begin
        len = $urandom_range(8, 1);
        repeat (len) send_sample(16'($urandom), 1'b0);
      end else if (kind < 98) begin
        len = $urandom_range(100, 90);
        repeat (len) send_sample(16'($urandom), 1'b0);
      end else begin
        len = 1;
        send_sample(16'($urandom), 1'($urandom_range(1)));
      end
      count += len;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(16'd500, 1'b0);
    send_sample(16'd100, 1'b1);
    send_sample(16'd700, 1'b1);
    send_sample(16'd65535, 1'b1);
    send_sample(16'd650, 1'b1);
    send_sample(16'd649, 1'b1);
    send_sample(16'd585, 1'b1);
    send_sample(16'd584, 1'b1);
    send_sample(16'd584, 1'b1);
    send_sample(16'd220, 1'b1);
    send_sample(16'd219, 1'b1);
    send_sample(16'd198, 1'b1);
    send_sample(16'd197, 1'b1);
    send_sample(16'd197, 1'b1);
    send_sample(16'd0, 1'b1);
    send_sample(16'hffff, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h5555, 1'b1);
    send_sample(16'haaaa, 1'b1);
    wait_idle();
    set_config(16'd300, 16'd100, 1'b1, 1'b1);
    send_sample(16'd200, 1'b1);
    send_sample(16'd50, 1'b1);
    send_sample(16'd350, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(mhl_pkg::FAIR_EDGE_RESET, mhl_pkg::POOR_EDGE_RESET, 1'b1, 1'b0);
        1: set_config(16'd0, 16'd0, 1'b1, 1'b0);
        2: set_config(16'hffff, 16'hffff, 1'b1, 1'b0);
        3: set_config(16'd1000, 16'd300, 1'b1, 1'b0);
        4: set_config(16'd400, 16'd900, 1'b0, 1'b0);
        5: set_config(16'd0, 16'hffff, 1'b1, 1'b0);
        default: set_config(16'($urandom_range(2000)), 16'($urandom_range(5000)),
                            1'b1, 1'b0);
      endcase
      calm <= (ph == 3);
      random_items(ITEMS_PER_PHASE);
    end

    s_tvalid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: median_hysteresis_level.f
src/mhl_pkg.sv
src/mhl_median.sv
src/mhl_judge.sv
src/median_hysteresis_level.sv
verif/testbench.sv
